>>> design/video_display_port_registers_macros.svh
// Assertion helpers used by the checker file
`ifndef VIDEO_DISPLAY_PORT_REGISTERS_MACROS_SVH
`define VIDEO_DISPLAY_PORT_REGISTERS_MACROS_SVH

// Same-cycle implication, checked also while reset is applied
`define VDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("vdp check failed");

// Next-cycle implication, dropped while reset is applied
`define VDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vdp check failed");

`endif

>>> design/vdp_pkg.sv
package vdp_pkg;

    // Video memory geometry
    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int PTR_W      = 14;

    // Bus operations
    localparam logic [1:0] OP_CTRL  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register numbers
    localparam logic [6:0] REG_MODE0   = 7'd0;
    localparam logic [6:0] REG_MODE1   = 7'd1;
    localparam logic [6:0] REG_NAME    = 7'd2;
    localparam logic [6:0] REG_COLOR   = 7'd3;
    localparam logic [6:0] REG_PATTERN = 7'd4;
    localparam logic [6:0] REG_SATTR   = 7'd5;
    localparam logic [6:0] REG_SPAT    = 7'd6;
    localparam logic [6:0] REG_COLORS  = 7'd7;

    // Display modes
    localparam logic [1:0] MODE_G1    = 2'd0;
    localparam logic [1:0] MODE_TEXT  = 2'd1;
    localparam logic [1:0] MODE_G2    = 2'd2;
    localparam logic [1:0] MODE_MULTI = 2'd3;

    // Decoded register state as seen on the result channel
    typedef struct packed {
        logic [1:0] video_mode;
        logic       display_on;
        logic       irq_enable;
        logic [3:0] name_table_base;
        logic [7:0] color_table_base;
        logic [2:0] pattern_table_base;
        logic [6:0] sprite_attr_base;
        logic [2:0] sprite_pattern_base;
        logic [3:0] foreground_color;
        logic [3:0] backdrop_color;
    } t_view;

    // Memory request from the port decode to the video memory
    typedef struct packed {
        logic               wr_en;
        logic [VRAM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [VRAM_AW-1:0] rd_addr;
    } t_mem_req;

    // Result held between pipeline stages
    typedef struct packed {
        t_view view;
        logic  overlay_clear;
        logic  is_read;
    } t_stage;

endpackage

>>> design/vdp_if.sv
interface vdp_cmd_if;
    import vdp_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface vdp_res_if;
    import vdp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] video_mode;
    logic       display_on;
    logic       irq_enable;
    logic [3:0] name_table_base;
    logic [7:0] color_table_base;
    logic [2:0] pattern_table_base;
    logic [6:0] sprite_attr_base;
    logic [2:0] sprite_pattern_base;
    logic [3:0] foreground_color;
    logic [3:0] backdrop_color;
    logic       overlay_clear;

    modport source (
        output valid, output read_data, output video_mode, output display_on,
        output irq_enable, output name_table_base, output color_table_base,
        output pattern_table_base, output sprite_attr_base,
        output sprite_pattern_base, output foreground_color,
        output backdrop_color, output overlay_clear, input ready
    );
    modport sink (
        input valid, input read_data, input video_mode, input display_on,
        input irq_enable, input name_table_base, input color_table_base,
        input pattern_table_base, input sprite_attr_base,
        input sprite_pattern_base, input foreground_color,
        input backdrop_color, input overlay_clear, output ready
    );
endinterface

>>> design/vdp_ram.sv
module vdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/vdp_ctrl.sv
module vdp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_value,
    output vdp_pkg::t_view    o_view,
    output logic              o_overlay_clear,
    output vdp_pkg::t_mem_req o_mem
);
    import vdp_pkg::*;

    logic [7:0]       r_latch,   n_latch;
    logic             r_pending, n_pending;
    logic [PTR_W-1:0] r_wptr,    n_wptr;
    logic [PTR_W-1:0] r_rptr,    n_rptr;
    logic [7:0]       r_reg0,    n_reg0;
    t_view            r_view,    n_view;
    logic             clear;
    logic [6:0]       reg_num;
    logic [1:0]       new_mode;
    logic             mode_write;

    assign reg_num = i_value[6:0];

    // Decode the port access into next register state
    always_comb begin
        n_latch    = r_latch;
        n_pending  = r_pending;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_reg0     = r_reg0;
        n_view     = r_view;
        clear      = 1'b0;
        new_mode   = r_view.video_mode;
        mode_write = 1'b0;
        case (i_operation)
            OP_CTRL: begin
                n_pending = ~r_pending;
                if (!r_pending) begin
                    n_latch = i_value;
                    n_wptr  = '0;
                    n_rptr  = '0;
                end else if (i_value[7]) begin
                    case (reg_num)
                        REG_MODE0: begin
                            n_reg0 = r_latch;
                            if (r_latch[1]) begin
                                new_mode   = MODE_G2;
                                mode_write = 1'b1;
                            end
                        end
                        REG_MODE1: begin
                            if (r_latch[3]) begin
                                new_mode   = MODE_MULTI;
                                mode_write = 1'b1;
                            end else if (r_latch[4]) begin
                                new_mode   = MODE_TEXT;
                                mode_write = 1'b1;
                            end else if (!r_reg0[1]) begin
                                new_mode   = MODE_G1;
                                mode_write = 1'b1;
                            end
                            n_view.irq_enable = r_latch[5];
                            n_view.display_on = r_latch[6];
                        end
                        REG_NAME:    n_view.name_table_base     = r_latch[3:0];
                        REG_COLOR:   n_view.color_table_base    = r_latch;
                        REG_PATTERN: n_view.pattern_table_base  = r_latch[2:0];
                        REG_SATTR:   n_view.sprite_attr_base    = r_latch[6:0];
                        REG_SPAT:    n_view.sprite_pattern_base = r_latch[2:0];
                        REG_COLORS: begin
                            n_view.foreground_color = r_latch[7:4];
                            n_view.backdrop_color   = r_latch[3:0];
                        end
                        default: ;
                    endcase
                    if (mode_write) begin
                        n_view.video_mode = new_mode;
                        clear = (new_mode != r_view.video_mode);
                    end
                    if (reg_num == REG_MODE1 && !r_latch[6]) begin
                        clear = 1'b1;
                    end
                end else begin
                    n_wptr = {i_value[5:0], r_latch};
                    n_rptr = {i_value[5:0], r_latch};
                end
            end
            OP_WRITE: n_wptr = r_wptr + PTR_W'(1);
            OP_READ:  n_rptr = r_rptr + PTR_W'(1);
            default: ;
        endcase
    end

    // Commit on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= '0;
            r_pending <= 1'b0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_reg0    <= '0;
            r_view    <= '{video_mode: MODE_G1, display_on: 1'b1, irq_enable: 1'b0,
                           name_table_base: '0, color_table_base: '0,
                           pattern_table_base: '0, sprite_attr_base: '0,
                           sprite_pattern_base: '0, foreground_color: 4'hF,
                           backdrop_color: 4'h0};
        end else if (i_accept) begin
            r_latch   <= n_latch;
            r_pending <= n_pending;
            r_wptr    <= n_wptr;
            r_rptr    <= n_rptr;
            r_reg0    <= n_reg0;
            r_view    <= n_view;
        end
    end

    // Memory access at the current pointers
    assign o_mem.wr_en   = i_accept && (i_operation == OP_WRITE);
    assign o_mem.wr_addr = r_wptr[VRAM_AW-1:0];
    assign o_mem.wr_data = i_value;
    assign o_mem.rd_en   = i_accept && (i_operation == OP_READ);
    assign o_mem.rd_addr = r_rptr[VRAM_AW-1:0];

    assign o_view          = n_view;
    assign o_overlay_clear = clear;
endmodule

>>> design/video_display_port_registers.sv
// Each accepted item passes through stage one and then the output register.
// Throughput: one item per cycle unless the result side stalls or the memory sweep
// runs; the video memory takes one access per item, its read port beside stage one.
// Reset: synchronous, active low; afterwards ready stays low while the video
// memory is swept to zero, one entry per cycle.
module video_display_port_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vdp_cmd_if.sink    i_cmd,
    vdp_res_if.source  o_res
);
    import vdp_pkg::*;

    logic               r_clearing;
    logic [VRAM_AW-1:0] r_clr_addr;
    logic               accept;
    logic               s1_adv;
    logic               r_s1_valid;
    t_stage             r_s1, n_s1;
    logic               r_o_valid;
    t_stage             r_o;
    logic [7:0]         r_o_data;
    t_view              view;
    logic               overlay_clear;
    t_mem_req           mem;
    logic [7:0]         ram_q;

    // Handshake: stage one moves on when the output register frees up
    assign s1_adv       = !r_o_valid || o_res.ready;
    assign i_cmd.ready  = !r_clearing && (!r_s1_valid || s1_adv);
    assign accept       = i_cmd.valid && i_cmd.ready;

    vdp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_cmd.operation),
        .i_value         (i_cmd.value),
        .o_view          (view),
        .o_overlay_clear (overlay_clear),
        .o_mem           (mem)
    );

    // Sweep the memory to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + VRAM_AW'(1);
            if (r_clr_addr == VRAM_AW'(VRAM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    vdp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || mem.wr_en),
        .i_waddr (r_clearing ? r_clr_addr : mem.wr_addr),
        .i_wdata (r_clearing ? 8'h00 : mem.wr_data),
        .i_re    (mem.rd_en),
        .i_raddr (mem.rd_addr),
        .o_rdata (ram_q)
    );

    assign n_s1.view          = view;
    assign n_s1.overlay_clear = overlay_clear;
    assign n_s1.is_read       = (i_cmd.operation == OP_READ);

    // Stage one: hold the decoded state while the memory read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // Output register: capture memory data for reads, zero otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_o      <= r_s1;
            r_o_data <= r_s1.is_read ? ram_q : 8'h00;
        end
    end

    assign o_res.valid               = r_o_valid;
    assign o_res.read_data           = r_o_data;
    assign o_res.video_mode          = r_o.view.video_mode;
    assign o_res.display_on          = r_o.view.display_on;
    assign o_res.irq_enable          = r_o.view.irq_enable;
    assign o_res.name_table_base     = r_o.view.name_table_base;
    assign o_res.color_table_base    = r_o.view.color_table_base;
    assign o_res.pattern_table_base  = r_o.view.pattern_table_base;
    assign o_res.sprite_attr_base    = r_o.view.sprite_attr_base;
    assign o_res.sprite_pattern_base = r_o.view.sprite_pattern_base;
    assign o_res.foreground_color    = r_o.view.foreground_color;
    assign o_res.backdrop_color      = r_o.view.backdrop_color;
    assign o_res.overlay_clear       = r_o.overlay_clear;
endmodule

>>> design/vdp_checker.sv
`include "video_display_port_registers_macros.svh"

module vdp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vdp_cmd_if.sink    i_cmd,
    vdp_res_if.source  o_res
);
    // A stalled result holds its payload
    `VDP_ASSERT_NEXT(a_res_hold, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.read_data) && $stable(o_res.overlay_clear))

    // Reset empties the result side
    `VDP_ASSERT_IMP(a_rst_empty, $past(!i_rst_n), !o_res.valid)

    // The memory sweep keeps the input closed right after reset
    `VDP_ASSERT_IMP(a_sweep_closed, $rose(i_rst_n), !i_cmd.ready)

    // Nothing comes out without an item in flight right after reset release
    `VDP_ASSERT_NEXT(a_no_invent, !o_res.valid && !i_cmd.ready && $past(!i_rst_n), !o_res.valid)
endmodule

bind video_display_port_registers vdp_checker u_vdp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .o_res   (o_res)
);

>>> tb/sv/tb.sv
module tb;
    import vdp_pkg::*;

    // Operation code with no side effect
    localparam logic [1:0] OP_NOP = 2'd3;

    // Run bounds: clearing sweep after reset plus generous room per item
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1900;

    // One result item: read byte, decoded register view, overlay event
    typedef struct packed {
        logic [7:0] read_data;
        t_view      view;
        logic       overlay_clear;
    } t_access_result;

    // One bus access, with optional typed-in values for the obvious fields
    typedef struct {
        logic [1:0] op;
        logic [7:0] value;
        bit         pinned;
        logic [7:0] read_data;
        logic [1:0] video_mode;
        logic       display_on;
        logic       irq_enable;
        logic       overlay_clear;
    } t_access_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vdp_cmd_if cmd_bus ();
    vdp_res_if res_bus ();

    video_display_port_registers dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always #10 i_clk = ~i_clk;

    // Shadow state of the port decode and video memory
    logic [7:0]  vram_shadow [VRAM_DEPTH];
    logic [7:0]  ctrl_latch;
    logic        ctrl_second;
    logic [13:0] wr_ptr;
    logic [13:0] rd_ptr;
    logic [7:0]  reg0_shadow;
    t_view       view_shadow;

    t_access_result expected_accesses [$];
    int unsigned    mismatch_count;
    int unsigned    cycle_count;
    int unsigned    item_count;
    int unsigned    src_gap_pct;
    int unsigned    sink_stall_pct;

    // Directed accesses starting from reset
    t_access_row directed_rows [26] = '{
        '{OP_READ,  8'h00, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_NOP,   8'hFF, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_CTRL,  8'hFF, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_CTRL,  8'h7F, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_WRITE, 8'hFF, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_WRITE, 8'hA5, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_READ,  8'h00, 1, 8'hFF, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_READ,  8'hFF, 1, 8'hA5, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_CTRL,  8'h02, 1, 8'h00, MODE_G1,    1'b1, 1'b0, 1'b0},
        '{OP_CTRL,  8'h80, 1, 8'h00, MODE_G2,    1'b1, 1'b0, 1'b1},
        '{OP_CTRL,  8'h00, 1, 8'h00, MODE_G2,    1'b1, 1'b0, 1'b0},
        '{OP_CTRL,  8'h81, 1, 8'h00, MODE_G2,    1'b0, 1'b0, 1'b1},
        '{OP_CTRL,  8'h78, 1, 8'h00, MODE_G2,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h81, 1, 8'h00, MODE_MULTI, 1'b1, 1'b1, 1'b1},
        '{OP_CTRL,  8'hFF, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h83, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'hFF, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h85, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h0F, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h87, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h55, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'hFF, 0, 8'h00, MODE_G1,    1'b0, 1'b0, 1'b0},
        '{OP_CTRL,  8'h00, 1, 8'h00, MODE_MULTI, 1'b1, 1'b1, 1'b0},
        '{OP_CTRL,  8'h80, 1, 8'h00, MODE_MULTI, 1'b1, 1'b1, 1'b0},
        '{OP_CTRL,  8'h50, 1, 8'h00, MODE_MULTI, 1'b1, 1'b1, 1'b0},
        '{OP_CTRL,  8'h81, 1, 8'h00, MODE_TEXT,  1'b1, 1'b0, 1'b1}
    };

    // Set the display mode, flag a change
    function automatic logic change_mode(logic [1:0] m);
        logic changed;
        changed = (m != view_shadow.video_mode);
        view_shadow.video_mode = m;
        return changed;
    endfunction

    // Apply a register write; return the overlay-clear event
    function automatic logic apply_register(logic [6:0] idx, logic [7:0] d);
        logic clr;
        clr = 1'b0;
        case (idx)
            REG_MODE0: begin
                reg0_shadow = d;
                if (d[1]) clr = change_mode(MODE_G2);
            end
            REG_MODE1: begin
                if (d[3]) clr = change_mode(MODE_MULTI);
                else if (d[4]) clr = change_mode(MODE_TEXT);
                else if (!reg0_shadow[1]) clr = change_mode(MODE_G1);
                view_shadow.irq_enable = d[5];
                view_shadow.display_on = d[6];
                if (!d[6]) clr = 1'b1;
            end
            REG_NAME:    view_shadow.name_table_base     = d[3:0];
            REG_COLOR:   view_shadow.color_table_base    = d;
            REG_PATTERN: view_shadow.pattern_table_base  = d[2:0];
            REG_SATTR:   view_shadow.sprite_attr_base    = d[6:0];
            REG_SPAT:    view_shadow.sprite_pattern_base = d[2:0];
            REG_COLORS: begin
                view_shadow.foreground_color = d[7:4];
                view_shadow.backdrop_color   = d[3:0];
            end
            default: ;
        endcase
        return clr;
    endfunction

    // Advance the shadow state by one access and return its result
    function automatic t_access_result predict_access(logic [1:0] op, logic [7:0] val);
        t_access_result r;
        r.read_data     = 8'h00;
        r.overlay_clear = 1'b0;
        case (op)
            OP_CTRL: begin
                if (!ctrl_second) begin
                    ctrl_latch = val;
                    wr_ptr     = '0;
                    rd_ptr     = '0;
                end else if (val[7]) begin
                    r.overlay_clear = apply_register(val[6:0], ctrl_latch);
                end else begin
                    wr_ptr = {val[5:0], ctrl_latch};
                    rd_ptr = {val[5:0], ctrl_latch};
                end
                ctrl_second = ~ctrl_second;
            end
            OP_WRITE: begin
                vram_shadow[int'(wr_ptr) % VRAM_DEPTH] = val;
                wr_ptr = wr_ptr + 14'd1;
            end
            OP_READ: begin
                r.read_data = vram_shadow[int'(rd_ptr) % VRAM_DEPTH];
                rd_ptr = rd_ptr + 14'd1;
            end
            default: ;
        endcase
        r.view = view_shadow;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_val,
                                   input int unsigned exp_val);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got_val, exp_val);
    endtask

    task automatic check_access(input t_access_result got, input t_access_result want);
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
        if (got.view.video_mode !== want.view.video_mode)
            report_mismatch("video_mode", 32'(got.view.video_mode),
                            32'(want.view.video_mode));
        if (got.view.display_on !== want.view.display_on)
            report_mismatch("display_on", 32'(got.view.display_on),
                            32'(want.view.display_on));
        if (got.view.irq_enable !== want.view.irq_enable)
            report_mismatch("irq_enable", 32'(got.view.irq_enable),
                            32'(want.view.irq_enable));
        if (got.view.name_table_base !== want.view.name_table_base)
            report_mismatch("name_table_base", 32'(got.view.name_table_base),
                            32'(want.view.name_table_base));
        if (got.view.color_table_base !== want.view.color_table_base)
            report_mismatch("color_table_base", 32'(got.view.color_table_base),
                            32'(want.view.color_table_base));
        if (got.view.pattern_table_base !== want.view.pattern_table_base)
            report_mismatch("pattern_table_base", 32'(got.view.pattern_table_base),
                            32'(want.view.pattern_table_base));
        if (got.view.sprite_attr_base !== want.view.sprite_attr_base)
            report_mismatch("sprite_attr_base", 32'(got.view.sprite_attr_base),
                            32'(want.view.sprite_attr_base));
        if (got.view.sprite_pattern_base !== want.view.sprite_pattern_base)
            report_mismatch("sprite_pattern_base", 32'(got.view.sprite_pattern_base),
                            32'(want.view.sprite_pattern_base));
        if (got.view.foreground_color !== want.view.foreground_color)
            report_mismatch("foreground_color", 32'(got.view.foreground_color),
                            32'(want.view.foreground_color));
        if (got.view.backdrop_color !== want.view.backdrop_color)
            report_mismatch("backdrop_color", 32'(got.view.backdrop_color),
                            32'(want.view.backdrop_color));
        if (got.overlay_clear !== want.overlay_clear)
            report_mismatch("overlay_clear", 32'(got.overlay_clear),
                            32'(want.overlay_clear));
    endtask

    // Drive one item from a falling edge, hold it until accepted, then queue its result
    task automatic send_access(input t_access_row row);
        t_access_result want;
        @(negedge i_clk);
        while ($urandom_range(99) < src_gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= row.op;
        cmd_bus.value     <= row.value;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        want = predict_access(row.op, row.value);
        if (row.pinned) begin
            want.read_data       = row.read_data;
            want.view.video_mode = row.video_mode;
            want.view.display_on = row.display_on;
            want.view.irq_enable = row.irq_enable;
            want.overlay_clear   = row.overlay_clear;
        end
        expected_accesses.push_back(want);
        item_count++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] val);
        t_access_row row;
        row = '{op, val, 1'b0, 8'h00, MODE_G1, 1'b0, 1'b0, 1'b0};
        send_access(row);
    endtask

    // Finish a dangling first byte so the next pair lines up
    task automatic align_ctrl();
        if (ctrl_second) send_op(OP_CTRL, 8'($urandom));
    endtask

    // Load both pointers, half the time near the bottom or top of memory
    task automatic set_pointer();
        logic [13:0] addr;
        case ($urandom_range(3))
            0:       addr = 14'($urandom_range(63));
            1:       addr = 14'h3FFF - 14'($urandom_range(63));
            default: addr = 14'($urandom);
        endcase
        align_ctrl();
        send_op(OP_CTRL, addr[7:0]);
        send_op(OP_CTRL, {1'b0, 1'($urandom), addr[13:8]});
    endtask

    task automatic drain_results();
        while (expected_accesses.size() != 0) @(posedge i_clk);
    endtask

    // Drop ready at random on falling edges
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check results on rising edges; bound the run
    always @(posedge i_clk) begin
        t_access_result seen;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            seen.read_data                = res_bus.read_data;
            seen.view.video_mode          = res_bus.video_mode;
            seen.view.display_on          = res_bus.display_on;
            seen.view.irq_enable          = res_bus.irq_enable;
            seen.view.name_table_base     = res_bus.name_table_base;
            seen.view.color_table_base    = res_bus.color_table_base;
            seen.view.pattern_table_base  = res_bus.pattern_table_base;
            seen.view.sprite_attr_base    = res_bus.sprite_attr_base;
            seen.view.sprite_pattern_base = res_bus.sprite_pattern_base;
            seen.view.foreground_color    = res_bus.foreground_color;
            seen.view.backdrop_color      = res_bus.backdrop_color;
            seen.overlay_clear            = res_bus.overlay_clear;
            if (expected_accesses.size() == 0)
                report_mismatch("result with no item pending", 32'(seen.read_data), 32'd0);
            else
                check_access(seen, expected_accesses.pop_front());
        end
    end

    initial begin
        int unsigned kind;
        int unsigned burst;
        bit          paused;

        // Known values on every input from time zero
        cmd_bus.valid     = 1'b0;
        cmd_bus.operation = OP_CTRL;
        cmd_bus.value     = 8'h00;
        res_bus.ready     = 1'b0;
        i_rst_n           = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        item_count        = 0;
        src_gap_pct       = 38;
        sink_stall_pct    = 38;
        paused            = 1'b0;

        // Shadow state at reset
        foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
        ctrl_latch  = 8'h00;
        ctrl_second = 1'b0;
        wr_ptr      = '0;
        rd_ptr      = '0;
        reg0_shadow = 8'h00;
        view_shadow = '0;
        view_shadow.display_on       = 1'b1;
        view_shadow.foreground_color = 4'hF;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed accesses
        foreach (directed_rows[i]) send_access(directed_rows[i]);

        // Random sequences, mostly well formed
        while (item_count < RANDOM_ITEMS) begin
            src_gap_pct    = (item_count >= 700 && item_count < 1000) ? 0 : 38;
            sink_stall_pct = src_gap_pct;

            // Hold off until every pending result is back, once
            if (!paused && item_count >= 1200) begin
                @(negedge i_clk);
                cmd_bus.valid <= 1'b0;
                drain_results();
                paused = 1'b1;
            end

            kind  = $urandom_range(99);
            burst = $urandom_range(1, 8);
            if (kind < 40) begin
                set_pointer();
                repeat (burst) send_op(OP_WRITE, 8'($urandom));
            end else if (kind < 65) begin
                set_pointer();
                repeat (burst) send_op(OP_READ, 8'($urandom));
            end else if (kind < 85) begin
                align_ctrl();
                send_op(OP_CTRL, 8'($urandom));
                if ($urandom_range(99) < 80)
                    send_op(OP_CTRL, {1'b1, 7'($urandom_range(7))});
                else
                    send_op(OP_CTRL, {1'b1, 7'($urandom_range(8, 127))});
            end else begin
                repeat ($urandom_range(1, 3))
                    send_op(2'($urandom_range(3)), 8'($urandom));
            end
        end

        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
